>>> rtl/core/mrac_pkg.sv
// ----------------------------------------------------------------------------
// MRAC package
// Shared widths, shift constants and the product descriptor for the
// serial multiply-round unit.
// ----------------------------------------------------------------------------
package mrac_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned ProdW  = 66;
    localparam int unsigned CntW   = 6;

    localparam logic [4:0] ShiftCoef = 5'd24;
    localparam logic [4:0] ShiftSig  = 5'd16;

    typedef struct packed {
        logic              start;
        logic signed [32:0] mcand;
        logic signed [32:0] mplier;
        logic [4:0]        shift;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic signed [49:0] rounded;
    } mul_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        hi = 52'sd2147483647;
        lo = -52'sd2147483648;
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

>>> rtl/core/mrac_adaptive_controller_core.sv
// ----------------------------------------------------------------------------
// MRAC adaptive controller core
// Second-order model reference adaptive controller. A sequencer runs the
// seventeen products of one tick through a single bit-serial multiplier.
//
// Channel  Dir  Contents
// s_axis   in   reference, measured, measured_rate
// m_axis   out  drive, three gains, model position and velocity
// cfg      in   register write, index 0..6
//
// Each product runs through an issue state, the multiplier's shift-add steps over
// all 33 multiplier bits and a completion strobe. One item takes 17 products;
// the next item can be taken in the cycle after the result is accepted.
// Reset clears the state, registers and the sequencer.
// A new item is taken only when the result register is free.
// ----------------------------------------------------------------------------
module mrac_adaptive_controller_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // reference [31:0], measured [63:32], measured_rate [95:64]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // drive, gain_reference_now, gain_output_now, gain_velocity_now,
    // model_position_now, model_velocity_now (32 bits each, low first)
    output logic [191:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam logic [2:0] RegStep = 3'd0;
    localparam logic [2:0] RegStiff = 3'd1;
    localparam logic [2:0] RegDamp = 3'd2;
    localparam logic [2:0] RegP21 = 3'd3;
    localparam logic [2:0] RegG1 = 3'd4;
    localparam logic [2:0] RegG2 = 3'd5;
    localparam logic [2:0] RegG3 = 3'd6;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StIssue = 2'd1;
    localparam logic [1:0] StWait = 2'd2;

    logic [30:0] step_reg, stiff_reg, p21_reg, g1_reg, g2_reg, g3_reg;
    logic signed [31:0] damp_reg;
    logic signed [31:0] pos_reg, vel_reg, th1_reg, th2_reg, th3_reg;
    logic signed [31:0] r_reg, y_reg, yd_reg, delta_reg, a_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] pos_next, vel_next, th1_next, th2_next, th3_next;
    logic signed [31:0] delta_next, a_next;
    logic signed [51:0] acc_next;
    logic [1:0]  state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic        ovalid_reg, ovalid_next;
    logic [191:0] odata_reg, odata_next;
    logic        take;
    mrac_pkg::mul_req_t req;
    mrac_pkg::mul_rsp_t rsp;
    logic signed [51:0] p;
    // Drive products: op 14 is theta1*r, op 15 runs theta2*y then
    // theta3*y_dot, selected by a sub-phase bit.
    logic sub_reg, sub_next;

    assign s_axis_tready = (state_reg == StIdle) && !ovalid_reg;
    assign take = s_axis_tvalid && s_axis_tready;
    assign p = 52'(rsp.rounded);

    mrac_serial_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    always_comb begin
        req.start  = (state_reg == StIssue);
        req.mcand  = '0;
        req.mplier = '0;
        req.shift  = mrac_pkg::ShiftCoef;
        unique case (op_reg)
            4'd0: begin req.mcand = 33'(signed'({1'b0, step_reg}));
                req.mplier = 33'(vel_reg); end
            4'd1: begin req.mcand = -33'(signed'({1'b0, stiff_reg}));
                req.mplier = 33'(pos_reg); end
            4'd2: begin req.mcand = 33'(damp_reg); req.mplier = 33'(vel_reg); end
            4'd3: begin req.mcand = 33'(signed'({1'b0, stiff_reg}));
                req.mplier = 33'(r_reg); end
            4'd4: begin req.mcand = 33'(signed'({1'b0, p21_reg}));
                req.mplier = 33'(y_reg) - 33'(pos_reg); end
            4'd5: begin req.mcand = 33'(signed'({1'b0, g1_reg}));
                req.mplier = 33'(delta_reg); end
            4'd6: begin req.mcand = 33'(a_reg); req.mplier = 33'(r_reg);
                req.shift = mrac_pkg::ShiftSig; end
            4'd7: begin req.mcand = 33'(signed'({1'b0, step_reg}));
                req.mplier = 33'(a_reg); end
            4'd8: begin req.mcand = 33'(signed'({1'b0, g2_reg}));
                req.mplier = 33'(delta_reg); end
            4'd9: begin req.mcand = 33'(a_reg); req.mplier = 33'(y_reg);
                req.shift = mrac_pkg::ShiftSig; end
            4'd10: begin req.mcand = 33'(signed'({1'b0, step_reg}));
                req.mplier = 33'(a_reg); end
            4'd11: begin req.mcand = 33'(signed'({1'b0, g3_reg}));
                req.mplier = 33'(delta_reg); end
            4'd12: begin req.mcand = 33'(a_reg); req.mplier = 33'(yd_reg);
                req.shift = mrac_pkg::ShiftSig; end
            4'd13: begin req.mcand = 33'(signed'({1'b0, step_reg}));
                req.mplier = 33'(a_reg); end
            4'd14: begin req.mcand = 33'(th1_reg); req.mplier = 33'(r_reg);
                req.shift = mrac_pkg::ShiftSig; end
            default: begin req.mcand = 33'(th3_reg); req.mplier = 33'(yd_reg);
                req.shift = mrac_pkg::ShiftSig; end
        endcase
        if (op_reg == 4'd15 && !sub_reg) begin
            req.mcand = 33'(th2_reg);
            req.mplier = 33'(y_reg);
        end
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        sub_next    = sub_reg;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        th1_next    = th1_reg;
        th2_next    = th2_reg;
        th3_next    = th3_reg;
        delta_next  = delta_reg;
        a_next      = a_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (ovalid_reg && m_axis_tready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            StIdle: begin
                if (take) begin
                    state_next = StIssue;
                    op_next    = 4'd0;
                    sub_next   = 1'b0;
                end
            end
            StIssue: state_next = StWait;
            default: begin
                if (rsp.done) begin
                    state_next = StIssue;
                    op_next    = op_reg + 4'd1;
                    unique case (op_reg)
                        4'd0: pos_next = mrac_pkg::sat32(52'(pos_reg) + p);
                        4'd1: acc_next = p;
                        4'd2: acc_next = acc_reg + p;
                        4'd3: vel_next = mrac_pkg::sat32(acc_reg + p);
                        4'd4: delta_next = mrac_pkg::sat32(p);
                        4'd5, 4'd8, 4'd11: a_next = mrac_pkg::sat32(p);
                        4'd6, 4'd9, 4'd12: a_next = mrac_pkg::sat32(p);
                        4'd7: th1_next = mrac_pkg::sat32(52'(th1_reg) - p);
                        4'd10: th2_next = mrac_pkg::sat32(52'(th2_reg) - p);
                        4'd13: th3_next = mrac_pkg::sat32(52'(th3_reg) - p);
                        4'd14: acc_next = p;
                        default: begin
                            if (!sub_reg) begin
                                acc_next = acc_reg + p;
                                sub_next = 1'b1;
                                op_next  = op_reg;
                            end else begin
                                state_next  = StIdle;
                                ovalid_next = 1'b1;
                                odata_next  = {vel_reg, pos_reg, th3_reg, th2_reg,
                                    th1_reg, mrac_pkg::sat32(acc_reg + p)};
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= StIdle;
            op_reg     <= '0;
            sub_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            step_reg <= '0; stiff_reg <= '0; damp_reg <= '0; p21_reg <= '0;
            g1_reg <= '0; g2_reg <= '0; g3_reg <= '0;
            pos_reg <= '0; vel_reg <= '0;
            th1_reg <= '0; th2_reg <= '0; th3_reg <= '0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            sub_reg    <= sub_next;
            ovalid_reg <= ovalid_next;
            pos_reg <= pos_next; vel_reg <= vel_next;
            th1_reg <= th1_next; th2_reg <= th2_next; th3_reg <= th3_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    RegStep:  step_reg  <= cfg_wdata[30:0];
                    RegStiff: stiff_reg <= cfg_wdata[30:0];
                    RegDamp:  damp_reg  <= cfg_wdata;
                    RegP21:   p21_reg   <= cfg_wdata[30:0];
                    RegG1:    g1_reg    <= cfg_wdata[30:0];
                    RegG2:    g2_reg    <= cfg_wdata[30:0];
                    RegG3:    g3_reg    <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
        end
        delta_reg <= delta_next;
        a_reg     <= a_next;
        acc_reg   <= acc_next;
        odata_reg <= odata_next;
        if (take) begin
            r_reg  <= s_axis_tdata[31:0];
            y_reg  <= s_axis_tdata[63:32];
            yd_reg <= s_axis_tdata[95:64];
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != StIdle) |-> !s_axis_tready) else $error("ready while busy");
    out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    issue_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == StIssue) |=> (state_reg == StWait)) else $error("issue");

endmodule

>>> rtl/core/mrac_serial_mul.sv
// ----------------------------------------------------------------------------
// MRAC serial multiplier
// Signed 33x33 shift-add multiplier, one multiplier bit per cycle, followed
// by round-to-nearest (ties up) and an arithmetic shift.
// ----------------------------------------------------------------------------
module mrac_serial_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  mrac_pkg::mul_req_t req,
    output mrac_pkg::mul_rsp_t rsp
);

    logic                   busy_reg, busy_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic signed [65:0]     acc_reg, acc_next;
    logic signed [65:0]     mc_reg, mc_next;
    logic [32:0]            mp_reg, mp_next;
    logic [4:0]             sh_reg, sh_next;
    logic                   done_reg, done_next;
    logic signed [65:0]     rounded;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        sh_next   = sh_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            acc_next  = '0;
            mc_next   = 66'(req.mcand);
            mp_next   = req.mplier;
            sh_next   = req.shift;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                if (cnt_reg == 6'd32) begin
                    acc_next = acc_reg - mc_reg;
                end else begin
                    acc_next = acc_reg + mc_reg;
                end
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd32) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        sh_reg  <= sh_next;
    end

    assign rounded = (acc_reg + (66'sd1 <<< (sh_reg - 5'd1))) >>> sh_reg;
    assign rsp.done    = done_reg;
    assign rsp.rounded = rounded[49:0];

    busy_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while busy");
    done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held");
    cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= 6'd32) else $error("count overrun");

endmodule

>>> dv/tb_mrac_adaptive_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MRAC adaptive controller core testbench
// Drives control ticks into the core under random bursts and output stalls.
// A behavioral controller model predicts each result, and the design output
// is compared with it as a whole result. The model is rerun through several
// register settings, extreme values included.
// ----------------------------------------------------------------------------
module tb_mrac_adaptive_controller_core;

    localparam int unsigned RegStep    = 0;
    localparam int unsigned RegStiff   = 1;
    localparam int unsigned RegDamp    = 2;
    localparam int unsigned RegWeight  = 3;
    localparam int unsigned RegRateRef = 4;
    localparam int unsigned RegRateOut = 5;
    localparam int unsigned RegRateVel = 6;
    localparam int unsigned NumRegs    = 7;
    localparam int unsigned StallLimit = 20000;

    typedef struct packed {
        logic [31:0] model_velocity;
        logic [31:0] model_position;
        logic [31:0] gain_velocity;
        logic [31:0] gain_output;
        logic [31:0] gain_reference;
        logic [31:0] drive;
    } tick_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    mrac_adaptive_controller_core dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    longint      coef [NumRegs];
    logic [31:0] ym, vm, th1, th2, th3;
    tick_out_t   expected_ticks [$];
    int          n_err = 0;
    int          n_ticks = 0;
    int          n_results = 0;
    int          idle_cycles = 0;
    bit          stall_mode = 1'b0;

    function automatic longint rnd(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [31:0] adapt_gain(logic [31:0] th, longint rate,
                                               logic [31:0] dl, logic [31:0] sg);
        logic [31:0] a;
        logic [31:0] b;
        a = sat(rnd(rate * sx(dl), 24));
        b = sat(rnd(sx(a) * sx(sg), 16));
        return sat(sx(th) - rnd(coef[RegStep] * sx(b), 24));
    endfunction

    function automatic tick_out_t predict_tick(logic [95:0] d);
        logic [31:0] r, y, yd, dl;
        tick_out_t   o;
        r  = d[31:0];
        y  = d[63:32];
        yd = d[95:64];
        ym = sat(sx(ym) + rnd(coef[RegStep] * sx(vm), 24));
        vm = sat(rnd(-coef[RegStiff] * sx(ym), 24) + rnd(coef[RegDamp] * sx(vm), 24)
                 + rnd(coef[RegStiff] * sx(r), 24));
        dl = sat(rnd(coef[RegWeight] * (sx(y) - sx(ym)), 24));
        th1 = adapt_gain(th1, coef[RegRateRef], dl, r);
        th2 = adapt_gain(th2, coef[RegRateOut], dl, y);
        th3 = adapt_gain(th3, coef[RegRateVel], dl, yd);
        o.drive = sat(rnd(sx(th1) * sx(r), 16) + rnd(sx(th2) * sx(y), 16)
                      + rnd(sx(th3) * sx(yd), 16));
        o.gain_reference = th1;
        o.gain_output = th2;
        o.gain_velocity = th3;
        o.model_position = ym;
        o.model_velocity = vm;
        return o;
    endfunction

    // Result checker and receiver stall pattern.
    always @(posedge aclk) begin
        tick_out_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            n_results <= n_results + 1;
            if (expected_ticks.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                n_err <= n_err + 1;
            end else begin
                want = expected_ticks.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    n_err <= n_err + 1;
                end
            end
        end
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > StallLimit) begin
            $display("watchdog timeout at %0t", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(int unsigned idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx[2:0];
        cfg_wdata <= val;
        if (idx < NumRegs) begin
            coef[idx] = (idx == RegDamp) ? sx(val) : longint'(val[30:0]);
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_tick(logic [31:0] r, logic [31:0] y, logic [31:0] yd);
        @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yd, y, r};
        do @(posedge aclk); while (!s_axis_tready);
        expected_ticks.push_back(predict_tick({yd, y, r}));
        n_ticks++;
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_coefs(bit extreme);
        for (int unsigned i = 0; i < NumRegs; i++) begin
            logic [31:0] v;
            if (extreme) begin
                v = (i == RegDamp) ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
                                   : 32'hffffffff;
            end else begin
                v = $urandom_range(0, 32'h00400000);
                if (i == RegDamp) v = 32'h01000000 - $urandom_range(0, 32'h00200000);
            end
            write_reg(i, v);
        end
    endtask

    task automatic test_directed;
        // Out-of-range index is dropped, extra bits above the width ignored.
        write_reg(7, 32'hffffffff);
        set_coefs(1'b0);
        send_tick(32'h7fffffff, 32'h80000000, 32'h0);
        send_tick(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_tick(32'h0, 32'h0, 32'h80000000);
        send_tick(32'h00010000, 32'hffff0000, 32'h00008000);
        drain();
        set_coefs(1'b1);
        for (int i = 0; i < 12; i++) send_tick(edge_val(), edge_val(), edge_val());
        drain();
    endtask

    task automatic test_random(int count, bit extreme);
        int burst;
        set_coefs(extreme);
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && count > 0; i++, count--) begin
                if ($urandom_range(0, 3) == 0) send_tick(edge_val(), edge_val(), edge_val());
                else send_tick($urandom_range(0, 32'h000fffff) - 32'h00080000,
                               $urandom_range(0, 32'h000fffff) - 32'h00080000,
                               $urandom);
            end
            repeat ($urandom_range(0, 40)) @(posedge aclk);
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < NumRegs; i++) coef[i] = 0;
        {ym, vm, th1, th2, th3} = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        for (int ph = 0; ph < 7; ph++) test_random(200, ph == 3);
        $display("Sent %0d ticks over 9 register settings, checked %0d results.",
                 n_ticks, n_results);
        if (n_err == 0 && expected_ticks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
